>>> hdl/chunked_transfer_deframer_top_macros.svh
// Assertion helpers used by the deframer top module.
`ifndef CHUNKED_TRANSFER_DEFRAMER_TOP_MACROS_SVH
`define CHUNKED_TRANSFER_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ctd_pkg.sv
package ctd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int COUNT_BITS  = 16;
  localparam int LIMIT_BITS  = 16;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;
  localparam logic [LIMIT_BITS-1:0]  CHUNK_CAP_RST = '1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Result tdata layout, lowest bit first.
  localparam int TD_PAYLOAD_LSB  = 0;
  localparam int TD_DONE_BIT     = 8;
  localparam int TD_LENGTH_LSB   = 9;
  localparam int TD_COUNT_LSB    = TD_LENGTH_LSB + LENGTH_BITS;
  localparam int TD_CONSUMED_LSB = TD_COUNT_LSB + COUNT_BITS;
  localparam int TD_STOPPED_BIT  = TD_CONSUMED_LSB + LENGTH_BITS;
  localparam int TD_USED_BITS    = TD_STOPPED_BIT + 1;
  localparam int OUT_TDATA_BITS  = ((TD_USED_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_CR = 3'd1,
    PH_DATA    = 3'd2,
    PH_TRAIL1  = 3'd3,
    PH_TRAIL2  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   payload_valid;
    logic [7:0]             payload_byte;
    logic                   chunk_done;
    logic [LENGTH_BITS-1:0] chunk_length;
    logic [COUNT_BITS-1:0]  chunk_count;
    logic [LENGTH_BITS-1:0] taken_bytes;
    logic                   stopped;
    logic                   buffer_done;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> hdl/chunked_transfer_deframer_top.sv
// Deframer for an HTTP chunked body, one byte per transaction. Each input
// byte yields exactly one result transaction via the input register and the
// result register; a new byte is accepted every cycle as long as the result
// side keeps up, since each byte's whole parse step (hex accumulate, length
// countdown, saturating totals) is combinational between the input register
// and the result register. Write the chunk limit only while no transaction
// is in flight; the parse state clears after a byte with tlast.
`include "chunked_transfer_deframer_top_macros.svh"

module chunked_transfer_deframer_top
  import ctd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [LIMIT_BITS-1:0]     cfg_wr_data,  // chunk limit
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,     // data_byte
  input  logic                      in_tlast,     // last_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // payload_byte[7:0], chunk_done[8], chunk_length[40:9], chunk_count[56:41],
  // taken_bytes[88:57], stopped[89], zero fill
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  output logic                      out_tuser,    // payload_valid
  output logic                      out_tlast     // buffer_done
);

  in_item_t in_item;
  in_item_t stage_item;
  logic     stage_valid;
  logic     stage_fire;
  logic     out_room;
  result_t  result;
  logic     res_stopped;
  logic     res_done;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;
  assign res_stopped       = out_tdata[TD_STOPPED_BIT];
  assign res_done          = out_tdata[TD_DONE_BIT];

  ctd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .down_room  (out_room),
    .stage_valid(stage_valid),
    .stage_item (stage_item),
    .stage_fire (stage_fire)
  );

  ctd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fire       (stage_fire),
    .item       (stage_item),
    .result     (result)
  );

  ctd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stage_fire),
    .result    (result),
    .room      (out_room),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  `CTD_ASSERT_IMPL(a_stop_quiet, out_tvalid && out_tuser, !res_stopped, "payload while stopped")
  `CTD_ASSERT_IMPL(a_done_not_payload, out_tvalid && res_done, !out_tuser, "chunk end on payload")
  `CTD_ASSERT_NEXT(a_accept_lands, in_tvalid && in_tready, stage_valid, "accepted byte lost")
  `CTD_ASSERT_NEXT(a_fire_lands, stage_fire, out_tvalid, "parsed byte lost")

endmodule

>>> hdl/ctd_in_stage.sv
module ctd_in_stage
  import ctd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     down_room,
  output logic     stage_valid,
  output in_item_t stage_item,
  output logic     stage_fire
);

  logic     valid_r;
  in_item_t item_r;

  assign stage_fire  = valid_r && down_room;
  assign in_ready    = !valid_r || down_room;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hdl/ctd_parser.sv
module ctd_parser
  import ctd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_BITS-1:0] cfg_wr_data,
  input  logic                  fire,
  input  in_item_t              item,
  output result_t               result
);

  logic [LIMIT_BITS-1:0]  chunk_cap_r;
  phase_t                 phase_r, phase_nxt;
  logic                   hex_ended_r, hex_ended_nxt;
  logic [LENGTH_BITS-1:0] length_r, length_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [LENGTH_BITS-1:0] pending_r, pending_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [LENGTH_BITS-1:0] consumed_r, consumed_nxt;
  logic                   limit_r, limit_nxt;

  logic                   limit_now;
  logic                   done;
  logic [LENGTH_BITS:0]   consumed_sum;
  hex_digit_t             digit;

  assign digit        = hex_decode(item.data_byte);
  assign consumed_sum = {1'b0, consumed_r} + {1'b0, pending_r} + {{LENGTH_BITS{1'b0}}, 1'b1};
  assign limit_now    = limit_r ||
                        (phase_r == PH_SIZE && pending_r == '0 &&
                         {{(32-COUNT_BITS){1'b0}}, count_r} >=
                         {{(32-LIMIT_BITS){1'b0}}, chunk_cap_r});

  always_comb begin
    phase_nxt     = phase_r;
    hex_ended_nxt = hex_ended_r;
    length_nxt    = length_r;
    left_nxt      = left_r;
    pending_nxt   = pending_r;
    count_nxt     = count_r;
    consumed_nxt  = consumed_r;
    limit_nxt     = limit_now;
    done          = 1'b0;
    result        = '0;

    if (!limit_now) begin
      pending_nxt = (pending_r == LEN_MAX) ? LEN_MAX : pending_r + 1'b1;
      unique case (phase_r)
        PH_SIZE_CR: begin
          if (item.data_byte == CHAR_LF) begin
            if (length_r == '0) begin
              phase_nxt = PH_TRAIL1;
            end else begin
              left_nxt  = length_r;
              phase_nxt = PH_DATA;
            end
          end else begin
            // lone CR stays part of the size line
            phase_nxt = (item.data_byte == CHAR_CR) ? PH_SIZE_CR : PH_SIZE;
          end
        end
        PH_DATA: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = item.data_byte;
          left_nxt             = left_r - 1'b1;
          if (left_r == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
            phase_nxt = PH_TRAIL1;
          end
        end
        PH_TRAIL1: begin
          phase_nxt = PH_TRAIL2;
        end
        PH_TRAIL2: begin
          done         = 1'b1;
          count_nxt    = (count_r == CNT_MAX) ? CNT_MAX : count_r + 1'b1;
          // pending + 1 folded into the carry; saturate on overflow
          consumed_nxt = (pending_r == LEN_MAX || consumed_sum[LENGTH_BITS]) ?
                         LEN_MAX : consumed_sum[LENGTH_BITS-1:0];
          pending_nxt  = '0;
          phase_nxt    = PH_SIZE;
          if ({{(32-COUNT_BITS){1'b0}}, count_nxt} >=
              {{(32-LIMIT_BITS){1'b0}}, chunk_cap_r}) begin
            limit_nxt = 1'b1;
          end
        end
        default: begin
          if (item.data_byte == CHAR_CR) begin
            phase_nxt = PH_SIZE_CR;
          end
          if (!hex_ended_r && digit.valid) begin
            length_nxt = (length_r[LENGTH_BITS-1 -: 4] != 4'd0) ? LEN_MAX :
                         {length_r[LENGTH_BITS-5:0], digit.value};
          end else begin
            hex_ended_nxt = 1'b1;
          end
        end
      endcase
    end

    result.chunk_done   = done;
    result.chunk_length = length_nxt;
    result.chunk_count  = count_nxt;
    result.taken_bytes  = consumed_nxt;
    result.stopped      = limit_nxt;
    result.buffer_done  = item.last_byte;

    if (done) begin
      length_nxt    = '0;
      hex_ended_nxt = 1'b0;
    end

    // end of buffer: start the next one from a clean parse
    if (item.last_byte) begin
      phase_nxt     = PH_SIZE;
      hex_ended_nxt = 1'b0;
      length_nxt    = '0;
      left_nxt      = '0;
      pending_nxt   = '0;
      count_nxt     = '0;
      consumed_nxt  = '0;
      limit_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_cap_r <= CHUNK_CAP_RST;
    end else if (cfg_wr_en) begin
      chunk_cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      hex_ended_r <= 1'b0;
      length_r    <= '0;
      left_r      <= '0;
      pending_r   <= '0;
      count_r     <= '0;
      consumed_r  <= '0;
      limit_r     <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      hex_ended_r <= hex_ended_nxt;
      length_r    <= length_nxt;
      left_r      <= left_nxt;
      pending_r   <= pending_nxt;
      count_r     <= count_nxt;
      consumed_r  <= consumed_nxt;
      limit_r     <= limit_nxt;
    end
  end

endmodule

>>> hdl/ctd_out_stage.sv
module ctd_out_stage
  import ctd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  result_t                   result,
  output logic                      room,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  output logic                      out_tuser,
  output logic                      out_tlast
);

  logic    valid_r;
  result_t res_r;

  assign room       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.payload_valid;
  assign out_tlast  = res_r.buffer_done;

  always_comb begin
    out_tdata = '0;
    out_tdata[TD_PAYLOAD_LSB +: 8]            = res_r.payload_byte;
    out_tdata[TD_DONE_BIT]                    = res_r.chunk_done;
    out_tdata[TD_LENGTH_LSB +: LENGTH_BITS]   = res_r.chunk_length;
    out_tdata[TD_COUNT_LSB +: COUNT_BITS]     = res_r.chunk_count;
    out_tdata[TD_CONSUMED_LSB +: LENGTH_BITS] = res_r.taken_bytes;
    out_tdata[TD_STOPPED_BIT]                 = res_r.stopped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule
